/* rtl/kmc_pkg.sv */
// kmc_pkg: sizes, command codes and control/status structs for the k-means block.
// Depends on nothing; kmc_datapath, kmc_ctrl and the top level refer to it by scoped names.
`timescale 1ns / 1ps
package kmc_pkg;

    localparam int MAX_PIXELS   = 65536;
    localparam int MAX_CLUSTERS = 8;

    localparam int AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CNTW  = $clog2(MAX_PIXELS + 1);
    localparam int SUMW  = CNTW + 8;
    localparam int CIW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int KW    = 3;
    localparam int RGBW  = 24;
    localparam int PIXW  = RGBW + KW;
    localparam int DISTW = 18;

    localparam logic [1:0] CMD_SEED  = 2'd0;
    localparam logic [1:0] CMD_TRAIN = 2'd1;
    localparam logic [1:0] CMD_MAP   = 2'd2;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_MAP    = 1'b1;

    localparam logic REG_NUM_CLUSTERS = 1'b0;
    localparam logic REG_MAX_ITER     = 1'b1;

    typedef struct packed {
        logic            take_seed;
        logic            take_train;
        logic            take_map;
        logic            last;
        logic            pass_start;
        logic            ld_pix;
        logic            srch_step;
        logic            srch_first;
        logic [KW-1:0]   k;
        logic            wb;
        logic [CNTW-1:0] idx;
        logic            div_init;
        logic            div_step;
        logic [2:0]      div_bit;
        logic [1:0]      div_chan;
        logic            div_store;
        logic            cent_wr;
        logic            pass_end;
        logic            emit_rep;
        logic            emit_map;
        logic            finish;
    } t_ctl;

    typedef struct packed {
        logic [3:0]      n;
        logic [CNTW-1:0] pix_cnt;
        logic            stop;
        logic            out_free;
    } t_stat;

endpackage

/* rtl/kmc_if.sv */
// kmc_in_if and kmc_out_if: valid/ready channels for input items and results.
// Depends on kmc_pkg for the command width only by convention (fixed widths).
`timescale 1ns / 1ps
interface kmc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
    modport source (output valid, cmd, red, green, blue, last, input ready);
    modport sink (input valid, cmd, red, green, blue, last, output ready);
endinterface

interface kmc_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [2:0] cluster_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] passes_done;
    logic       converged;
    logic       overflow;
    logic       final_res;
    modport source (output valid, kind, cluster_index, out_red, out_green, out_blue,
                    passes_done, converged, overflow, final_res, input ready);
    modport sink (input valid, kind, cluster_index, out_red, out_green, out_blue,
                  passes_done, converged, overflow, final_res, output ready);
endinterface

/* rtl/kmc_ram.sv */
// kmc_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module kmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/kmc_datapath.sv */
// kmc_datapath: pixel store, centroids, sums, shared divider and output register.
// Depends on kmc_pkg and kmc_ram; driven by kmc_ctrl through t_ctl.
`timescale 1ns / 1ps
module kmc_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kmc_pkg::t_ctl        i_ctl,
    output kmc_pkg::t_stat       o_stat,
    input  logic [3:0]           i_n,
    input  logic [7:0]           i_limit,
    input  logic [7:0]           i_red,
    input  logic [7:0]           i_green,
    input  logic [7:0]           i_blue,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_kind,
    output logic [2:0]           o_cluster_index,
    output logic [7:0]           o_out_red,
    output logic [7:0]           o_out_green,
    output logic [7:0]           o_out_blue,
    output logic [7:0]           o_passes_done,
    output logic                 o_converged,
    output logic                 o_overflow,
    output logic                 o_final_res
);
    logic [kmc_pkg::RGBW-1:0]  r_cent [kmc_pkg::MAX_CLUSTERS];
    logic [kmc_pkg::SUMW-1:0]  r_sum  [kmc_pkg::MAX_CLUSTERS][3];
    logic [kmc_pkg::CNTW-1:0]  r_cnt  [kmc_pkg::MAX_CLUSTERS];
    logic [kmc_pkg::RGBW-1:0]  r_pix;
    logic [kmc_pkg::KW-1:0]    r_old;
    logic [kmc_pkg::KW-1:0]    r_best;
    logic [kmc_pkg::DISTW-1:0] r_bestd;
    logic [kmc_pkg::RGBW-1:0]  r_best_rgb;
    logic                      r_changed;
    logic [7:0]                r_passes;
    logic                      r_conv;
    logic [kmc_pkg::CNTW-1:0]  r_pcnt;
    logic [3:0]                r_scnt;
    logic                      r_ovf;
    logic [kmc_pkg::SUMW-1:0]  r_rem;
    logic [kmc_pkg::CNTW-1:0]  r_div;
    logic [7:0]                r_q;
    logic [kmc_pkg::RGBW-1:0]  r_newc;

    logic [kmc_pkg::CIW-1:0]   kc;
    logic [kmc_pkg::RGBW-1:0]  cq;
    logic [7:0]                dr, dg, db;
    logic [kmc_pkg::DISTW-1:0] sq_dist;
    logic [kmc_pkg::SUMW-1:0]  dshift;
    logic                      store_ok;
    logic                      ram_we;
    logic [kmc_pkg::AW-1:0]    ram_waddr;
    logic [kmc_pkg::PIXW-1:0]  ram_wdata;
    logic [kmc_pkg::PIXW-1:0]  ram_rdata;
    logic [kmc_pkg::CIW-1:0]   bc;
    logic [kmc_pkg::RGBW-1:0]  in_rgb;

    assign kc     = i_ctl.k[kmc_pkg::CIW-1:0];
    assign bc     = r_best[kmc_pkg::CIW-1:0];
    assign cq     = r_cent[kc];
    assign in_rgb = {i_red, i_green, i_blue};

    always_comb begin
        dr = (r_pix[23:16] >= cq[23:16]) ? r_pix[23:16] - cq[23:16] : cq[23:16] - r_pix[23:16];
        dg = (r_pix[15:8] >= cq[15:8]) ? r_pix[15:8] - cq[15:8] : cq[15:8] - r_pix[15:8];
        db = (r_pix[7:0] >= cq[7:0]) ? r_pix[7:0] - cq[7:0] : cq[7:0] - r_pix[7:0];
        sq_dist = kmc_pkg::DISTW'(16'(dr * dr)) + kmc_pkg::DISTW'(16'(dg * dg))
                + kmc_pkg::DISTW'(16'(db * db));
    end

    assign dshift   = kmc_pkg::SUMW'(r_div) << i_ctl.div_bit;
    assign store_ok = r_pcnt < kmc_pkg::CNTW'(kmc_pkg::MAX_PIXELS);

    assign ram_we    = (i_ctl.take_train && store_ok) || i_ctl.wb;
    assign ram_waddr = i_ctl.wb ? i_ctl.idx[kmc_pkg::AW-1:0] : r_pcnt[kmc_pkg::AW-1:0];
    assign ram_wdata = i_ctl.wb ? {r_best, r_pix} : {kmc_pkg::KW'(0), in_rgb};

    kmc_ram #(
        .WIDTH(kmc_pkg::PIXW),
        .DEPTH(kmc_pkg::MAX_PIXELS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(i_ctl.idx[kmc_pkg::AW-1:0]),
        .o_rdata(ram_rdata)
    );

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.take_seed && (r_scnt < i_n)) begin
            r_cent[r_scnt[kmc_pkg::CIW-1:0]] <= in_rgb;
        end
        if (i_ctl.take_map) begin
            r_pix <= in_rgb;
        end
        if (i_ctl.ld_pix) begin
            r_pix <= ram_rdata[kmc_pkg::RGBW-1:0];
            r_old <= ram_rdata[kmc_pkg::PIXW-1:kmc_pkg::RGBW];
        end
        if (i_ctl.srch_step && (i_ctl.srch_first || (sq_dist < r_bestd))) begin
            r_best     <= i_ctl.k;
            r_bestd    <= sq_dist;
            r_best_rgb <= cq;
        end
        if (i_ctl.pass_start) begin
            for (int c = 0; c < kmc_pkg::MAX_CLUSTERS; c++) begin
                r_cnt[c] <= '0;
                for (int h = 0; h < 3; h++) begin
                    r_sum[c][h] <= '0;
                end
            end
            r_changed <= (r_passes == 8'd0);
        end
        if (i_ctl.wb) begin
            r_sum[bc][0] <= r_sum[bc][0] + kmc_pkg::SUMW'(r_pix[23:16]);
            r_sum[bc][1] <= r_sum[bc][1] + kmc_pkg::SUMW'(r_pix[15:8]);
            r_sum[bc][2] <= r_sum[bc][2] + kmc_pkg::SUMW'(r_pix[7:0]);
            r_cnt[bc]    <= r_cnt[bc] + kmc_pkg::CNTW'(1);
            if (r_best != r_old) begin
                r_changed <= 1'b1;
            end
        end
        if (i_ctl.div_init) begin
            r_rem <= r_sum[kc][i_ctl.div_chan];
            r_div <= r_cnt[kc];
            r_q   <= '0;
        end
        if (i_ctl.div_step && (r_rem >= dshift)) begin
            r_rem             <= r_rem - dshift;
            r_q[i_ctl.div_bit] <= 1'b1;
        end
        if (i_ctl.div_store) begin
            case (i_ctl.div_chan)
                2'd0:    r_newc[23:16] <= r_q;
                2'd1:    r_newc[15:8]  <= r_q;
                default: r_newc[7:0]   <= r_q;
            endcase
        end
        if (i_ctl.cent_wr) begin
            r_cent[kc] <= (r_cnt[kc] == '0) ? '0 : r_newc;
        end
        if (i_ctl.emit_rep) begin
            o_kind          <= kmc_pkg::KIND_REPORT;
            o_cluster_index <= i_ctl.k;
            o_out_red       <= cq[23:16];
            o_out_green     <= cq[15:8];
            o_out_blue      <= cq[7:0];
            o_passes_done   <= r_passes;
            o_converged     <= r_conv;
            o_overflow      <= r_ovf;
            o_final_res     <= ({1'b0, i_ctl.k} + 4'd1) == i_n;
        end
        if (i_ctl.emit_map) begin
            o_kind          <= kmc_pkg::KIND_MAP;
            o_cluster_index <= r_best;
            o_out_red       <= r_best_rgb[23:16];
            o_out_green     <= r_best_rgb[15:8];
            o_out_blue      <= r_best_rgb[7:0];
            o_passes_done   <= 8'd0;
            o_converged     <= 1'b0;
            o_overflow      <= 1'b0;
            o_final_res     <= 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt      <= '0;
            r_scnt      <= '0;
            r_ovf       <= 1'b0;
            r_passes    <= '0;
            r_conv      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_ctl.take_seed && (r_scnt < i_n)) begin
                r_scnt <= r_scnt + 4'd1;
            end
            if (i_ctl.take_train) begin
                if (store_ok) begin
                    r_pcnt <= r_pcnt + kmc_pkg::CNTW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
                if (i_ctl.last) begin
                    r_passes <= '0;
                    r_conv   <= 1'b0;
                end
            end
            if (i_ctl.pass_end) begin
                r_passes <= r_passes + 8'd1;
                r_conv   <= !r_changed;
            end
            if (i_ctl.finish) begin
                r_pcnt <= '0;
                r_scnt <= '0;
                r_ovf  <= 1'b0;
            end
            if (i_ctl.emit_rep || i_ctl.emit_map) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.n        = i_n;
    assign o_stat.pix_cnt  = r_pcnt;
    assign o_stat.stop     = !r_changed || (({1'b0, r_passes} + 9'd1) >= {1'b0, i_limit});
    assign o_stat.out_free = !o_out_valid || i_out_ready;
endmodule

/* rtl/kmc_ctrl.sv */
// kmc_ctrl: sequencer for load, assign, divide, report and map phases.
// Depends on kmc_pkg; drives kmc_datapath through t_ctl only.
`timescale 1ns / 1ps
module kmc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_in_cmd,
    input  logic           i_in_last,
    output logic           o_in_ready,
    input  kmc_pkg::t_stat i_stat,
    output kmc_pkg::t_ctl  o_ctl
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PASS  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_LD    = 4'd3;
    localparam logic [3:0] S_SRCH  = 4'd4;
    localparam logic [3:0] S_WB    = 4'd5;
    localparam logic [3:0] S_DIVI  = 4'd6;
    localparam logic [3:0] S_DIVS  = 4'd7;
    localparam logic [3:0] S_DIVW  = 4'd8;
    localparam logic [3:0] S_CENT  = 4'd9;
    localparam logic [3:0] S_CHK   = 4'd10;
    localparam logic [3:0] S_REP   = 4'd11;
    localparam logic [3:0] S_MSRCH = 4'd12;
    localparam logic [3:0] S_MOUT  = 4'd13;

    logic [3:0]               r_state, n_state;
    logic [kmc_pkg::KW-1:0]   r_k, n_k;
    logic [kmc_pkg::CNTW-1:0] r_i, n_i;
    logic [2:0]               r_bit, n_bit;
    logic [1:0]               r_chan, n_chan;
    logic                     accept;
    logic                     k_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign k_last     = ({1'b0, r_k} + 4'd1) == i_stat.n;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_i     = r_i;
        n_bit   = r_bit;
        n_chan  = r_chan;
        o_ctl   = '0;
        o_ctl.k        = r_k;
        o_ctl.idx      = r_i;
        o_ctl.div_bit  = r_bit;
        o_ctl.div_chan = r_chan;
        o_ctl.last     = i_in_last;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_cmd)
                        kmc_pkg::CMD_SEED: o_ctl.take_seed = 1'b1;
                        kmc_pkg::CMD_TRAIN: begin
                            o_ctl.take_train = 1'b1;
                            if (i_in_last) begin
                                n_state = S_PASS;
                            end
                        end
                        kmc_pkg::CMD_MAP: begin
                            o_ctl.take_map = 1'b1;
                            n_k            = '0;
                            n_state        = S_MSRCH;
                        end
                        default: ;
                    endcase
                end
            end
            S_PASS: begin
                o_ctl.pass_start = 1'b1;
                n_i = '0;
                n_k = '0;
                n_chan = '0;
                n_state = (i_stat.pix_cnt == '0) ? S_DIVI : S_RD;
            end
            S_RD: n_state = S_LD;
            S_LD: begin
                o_ctl.ld_pix = 1'b1;
                n_k = '0;
                n_state = S_SRCH;
            end
            S_SRCH: begin
                o_ctl.srch_step  = 1'b1;
                o_ctl.srch_first = (r_k == '0);
                if (k_last) begin
                    n_state = S_WB;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_WB: begin
                o_ctl.wb = 1'b1;
                if ((r_i + kmc_pkg::CNTW'(1)) == i_stat.pix_cnt) begin
                    n_k = '0;
                    n_chan = '0;
                    n_state = S_DIVI;
                end else begin
                    n_i = r_i + kmc_pkg::CNTW'(1);
                    n_state = S_RD;
                end
            end
            S_DIVI: begin
                o_ctl.div_init = 1'b1;
                n_bit = 3'd7;
                n_state = S_DIVS;
            end
            S_DIVS: begin
                o_ctl.div_step = 1'b1;
                if (r_bit == 3'd0) begin
                    n_state = S_DIVW;
                end else begin
                    n_bit = r_bit - 3'd1;
                end
            end
            S_DIVW: begin
                o_ctl.div_store = 1'b1;
                if (r_chan == 2'd2) begin
                    n_state = S_CENT;
                end else begin
                    n_chan = r_chan + 2'd1;
                    n_state = S_DIVI;
                end
            end
            S_CENT: begin
                o_ctl.cent_wr = 1'b1;
                n_chan = '0;
                if (k_last) begin
                    n_state = S_CHK;
                end else begin
                    n_k = r_k + 3'd1;
                    n_state = S_DIVI;
                end
            end
            S_CHK: begin
                o_ctl.pass_end = 1'b1;
                n_k = '0;
                n_state = i_stat.stop ? S_REP : S_PASS;
            end
            S_REP: begin
                if (i_stat.out_free) begin
                    o_ctl.emit_rep = 1'b1;
                    if (k_last) begin
                        o_ctl.finish = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end
            end
            S_MSRCH: begin
                o_ctl.srch_step  = 1'b1;
                o_ctl.srch_first = (r_k == '0);
                if (k_last) begin
                    n_state = S_MOUT;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_MOUT: begin
                if (i_stat.out_free) begin
                    o_ctl.emit_map = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_i     <= '0;
            r_bit   <= '0;
            r_chan  <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            r_bit   <= n_bit;
            r_chan  <= n_chan;
        end
    end

`ifndef SYNTHESIS
    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SRCH) || (r_state == S_MSRCH) || (r_state == S_REP))
        |-> ({1'b0, r_k} < i_stat.n))
        else $error("centroid counter past clusters in use");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.emit_rep || o_ctl.emit_map) |-> i_stat.out_free)
        else $error("result issued into a full output register");
    a_pass_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WB) && ((r_i + kmc_pkg::CNTW'(1)) == i_stat.pix_cnt))
        |=> (r_state == S_DIVI))
        else $error("assign pass did not hand over to the update");
`endif
endmodule

/* rtl/kmeans_color_clustering.sv */
// Seed and training transfers are taken while idle; a map answer follows a search over
// the n clusters in use (one distance per cycle) and waits for a free output register.
// A clustering pass over the P stored pixels is paced by the single distance unit and
// the bit-serial divider (8 steps per channel).
// Report emits n results, one per cycle while the sink takes them.
// Reset (synchronous, active low) clears counts and flags; pixel store needs no clear.
`timescale 1ns / 1ps
module kmeans_color_clustering (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kmc_in_if.sink       i_in,
    kmc_out_if.source    o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [3:0]     r_num_clusters;
    logic [7:0]     r_max_iter;
    logic [3:0]     n_use;
    logic [7:0]     limit;
    logic           cfg_wr;
    kmc_pkg::t_ctl  ctl;
    kmc_pkg::t_stat stat;

    // Register file: one transfer per access phase, always ready.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_clusters <= 4'd8;
            r_max_iter     <= 8'd100;
        end else if (cfg_wr) begin
            case (paddr[2])
                kmc_pkg::REG_NUM_CLUSTERS: r_num_clusters <= pwdata[3:0];
                kmc_pkg::REG_MAX_ITER:     r_max_iter     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == kmc_pkg::REG_MAX_ITER) ? {24'd0, r_max_iter}
                                                         : {28'd0, r_num_clusters};

    // Clamp the registers: zero clusters or a zero iteration limit acts as one, too many clusters act as the maximum.
    always_comb begin
        if (r_num_clusters == 4'd0) begin
            n_use = 4'd1;
        end else if (r_num_clusters > 4'(kmc_pkg::MAX_CLUSTERS)) begin
            n_use = 4'(kmc_pkg::MAX_CLUSTERS);
        end else begin
            n_use = r_num_clusters;
        end
        limit = (r_max_iter == 8'd0) ? 8'd1 : r_max_iter;
    end

    kmc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .i_in_cmd  (i_in.cmd),
        .i_in_last (i_in.last),
        .o_in_ready(i_in.ready),
        .i_stat    (stat),
        .o_ctl     (ctl)
    );

    kmc_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_stat         (stat),
        .i_n            (n_use),
        .i_limit        (limit),
        .i_red          (i_in.red),
        .i_green        (i_in.green),
        .i_blue         (i_in.blue),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_kind         (o_out.kind),
        .o_cluster_index(o_out.cluster_index),
        .o_out_red      (o_out.out_red),
        .o_out_green    (o_out.out_green),
        .o_out_blue     (o_out.out_blue),
        .o_passes_done  (o_out.passes_done),
        .o_converged    (o_out.converged),
        .o_overflow     (o_out.overflow),
        .o_final_res    (o_out.final_res)
    );
endmodule
